>>> sv/prime_gap_encoder_defines.svh
// ----------------------------------------------------------------------------
// Prime gap encoder assertion macros
// Shared assertion shorthands for the prime gap encoder RTL.
// ----------------------------------------------------------------------------
`ifndef PRIME_GAP_ENCODER_DEFINES_SVH
`define PRIME_GAP_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PGE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prime_gap_encoder: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define PGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prime_gap_encoder: next-cycle check failed");

`endif

>>> sv/pge_pkg.sv
// ----------------------------------------------------------------------------
// Prime gap encoder package
// Types, constants and the CRC / gap table functions.
// ----------------------------------------------------------------------------
package pge_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int VALUE_BYTES = (VALUE_BITS + 7) / 8;
  localparam int CODE_W      = 40;
  localparam int LEN_W       = 6;
  localparam int CRC_W       = 32;
  localparam int DATA_W      = 32;

  localparam logic [DATA_W-1:0] VALUE_MASK = 32'hFFFF_FFFF >> (32 - VALUE_BITS);
  localparam logic [CRC_W-1:0]  CRC_POLY   = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]  CRC_INIT   = 32'hFFFF_FFFF;

  // tier codes (high nibble of a gap table entry)
  localparam logic [3:0] TIER_NONE = 4'h0;
  localparam logic [3:0] TIER_1    = 4'h1;
  localparam logic [3:0] TIER_2    = 4'h2;
  localparam logic [3:0] TIER_3    = 4'h3;

  localparam logic [7:0] ESC_PREFIX   = 8'hFF;
  localparam logic [7:0] SHORT_PREFIX = 8'hFE;
  localparam logic [3:0] TIER2_PREFIX = 4'hC;
  localparam logic [6:0] TIER3_PREFIX = 7'h78;

  typedef enum logic [1:0] {
    STAT_GAP = 2'd0,
    STAT_END = 2'd1,
    STAT_ERR = 2'd2
  } status_e;

  typedef enum logic {
    MODE_VALUE = 1'b0,
    MODE_END   = 1'b1
  } mode_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } pge_code_t;

  // gap table: tier in high nibble, data in low nibble
  function automatic logic [7:0] gap_entry(input logic [3:0] d);
    logic [7:0] r;
    case (d)
      4'd1:    r = {TIER_2, 4'h0};
      4'd2:    r = {TIER_2, 4'h1};
      4'd3:    r = {TIER_1, 4'h0};
      4'd4:    r = {TIER_3, 4'h0};
      4'd5:    r = {TIER_1, 4'h2};
      4'd6:    r = {TIER_1, 4'h1};
      4'd7:    r = {TIER_3, 4'h1};
      4'd8:    r = {TIER_3, 4'h2};
      4'd9:    r = {TIER_2, 4'h2};
      4'd10:   r = {TIER_3, 4'h3};
      4'd11:   r = {TIER_3, 4'h4};
      4'd12:   r = {TIER_3, 4'h5};
      4'd15:   r = {TIER_3, 4'h6};
      default: r = {TIER_NONE, 4'h0};
    endcase
    return r;
  endfunction

  // reflected CRC-32 over the value bytes, low byte first
  function automatic logic [CRC_W-1:0] crc_value(input logic [CRC_W-1:0] crc,
                                                 input logic [DATA_W-1:0] v);
    logic [CRC_W-1:0] c;
    c = crc;
    for (int b = 0; b < VALUE_BYTES; b++) begin
      c = c ^ {24'd0, v[8*b +: 8]};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

endpackage

>>> sv/prime_gap_encoder.sv
// ----------------------------------------------------------------------------
// Prime gap encoder
// Checks a rising prime list, codes each halved gap, keeps a CRC-32.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                        | tuser
//  s_axis   | in  | value[31:0]                                  | mode
//  m_axis   | out | code[39:0] len[45:40] crc[77:46] mism[78]    | status[1:0]
//
//  One request per cycle sustained while results are taken; requests pass the
//  input register, then the result register. Gap coding and the four-byte CRC
//  sit between the two. Primes 2 and 3 produce no result. Reset clears all control
//  and presets the CRC. A stalled result holds in the output register while the input
//  register takes the next request; the input side stalls only when both are full.
// ----------------------------------------------------------------------------
`include "prime_gap_encoder_defines.svh"

module prime_gap_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // value[31:0]
  input  logic        s_axis_tuser_i,   // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // code[39:0], len[45:40], crc[77:46], mism[78]
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);

  // input register
  logic                       in_valid_q;
  logic                       in_mode_q;
  logic [pge_pkg::DATA_W-1:0] in_value_q;
  logic                       in_go;

  // block state
  logic [pge_pkg::DATA_W-1:0] prev_q, prev_d;
  logic [pge_pkg::CRC_W-1:0]  crc_q, crc_d;
  logic                       stopped_q, stopped_d;

  // result register
  logic                         out_valid_q, out_valid_d;
  pge_pkg::status_e             out_status_q, out_status_d;
  logic [pge_pkg::CODE_W-1:0]   out_code_q, out_code_d;
  logic [pge_pkg::LEN_W-1:0]    out_len_q, out_len_d;
  logic [pge_pkg::CRC_W-1:0]    out_crc_q, out_crc_d;
  logic                         out_mism_q, out_mism_d;

  pge_pkg::pge_code_t         gap_code;
  logic [pge_pkg::CRC_W-1:0]  crc_fin;
  logic                       bad_value;

  assign in_go           = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || in_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_mode_q  <= s_axis_tuser_i;
      in_value_q <= s_axis_tdata_i;
    end
  end

  pge_coder u_coder (
    .value_i (in_value_q),
    .prev_i  (prev_q),
    .code_o  (gap_code)
  );

  assign crc_fin   = ~crc_q;
  assign bad_value = ((in_value_q & ~pge_pkg::VALUE_MASK) != '0)
                  || ((prev_q != '0) ? (in_value_q <= prev_q)
                                     : (in_value_q != pge_pkg::DATA_W'(2)));

  always_comb begin
    prev_d       = prev_q;
    crc_d        = crc_q;
    stopped_d    = stopped_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_code_d   = out_code_q;
    out_len_d    = out_len_q;
    out_crc_d    = out_crc_q;
    out_mism_d   = out_mism_q;
    if (in_go) begin
      out_valid_d  = 1'b1;
      out_status_d = pge_pkg::STAT_ERR;
      out_code_d   = '0;
      out_len_d    = '0;
      out_crc_d    = '0;
      out_mism_d   = 1'b0;
      if (stopped_q) begin
        stopped_d = 1'b1;
      end else if (in_mode_q == pge_pkg::MODE_END) begin
        stopped_d = 1'b1;
        if (prev_q != '0) begin
          out_status_d = pge_pkg::STAT_END;
          out_code_d   = pge_pkg::CODE_W'(pge_pkg::ESC_PREFIX) << pge_pkg::VALUE_BITS;
          out_len_d    = pge_pkg::LEN_W'(8 + pge_pkg::VALUE_BITS);
          out_crc_d    = crc_fin;
          out_mism_d   = (crc_fin != in_value_q);
        end
      end else if (bad_value) begin
        stopped_d = 1'b1;
      end else begin
        crc_d  = pge_pkg::crc_value(crc_q, in_value_q);
        prev_d = in_value_q;
        if (in_value_q <= pge_pkg::DATA_W'(3)) begin
          // first primes only feed the CRC
          out_valid_d = 1'b0;
        end else begin
          out_status_d = pge_pkg::STAT_GAP;
          out_code_d   = gap_code.code;
          out_len_d    = gap_code.len;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      crc_q       <= pge_pkg::CRC_INIT;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      crc_q       <= crc_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_code_q   <= out_code_d;
    out_len_q    <= out_len_d;
    out_crc_q    <= out_crc_d;
    out_mism_q   <= out_mism_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {1'b0, out_mism_q, out_crc_q, out_len_q, out_code_q};

  `PGE_ASSERT_NEXT(a_stop_sticky, clk_i, rst_ni, stopped_q, stopped_q)
  `PGE_ASSERT_NEXT(a_crc_hold, clk_i, rst_ni, !in_go, $stable(crc_q) && $stable(prev_q))
  `PGE_ASSERT_NOW(a_err_clean, clk_i, rst_ni,
    out_valid_q && out_status_q == pge_pkg::STAT_ERR,
    out_len_q == '0 && out_crc_q == '0 && !out_mism_q)
  `PGE_ASSERT_NOW(a_gap_len, clk_i, rst_ni,
    out_valid_q && out_status_q == pge_pkg::STAT_GAP,
    out_len_q == 6'd2 || out_len_q == 6'd4 || out_len_q == 6'd7 ||
    out_len_q == 6'd16 || out_len_q == 6'd40)
  `PGE_ASSERT_NEXT(a_end_stops, clk_i, rst_ni,
    in_go && in_mode_q == pge_pkg::MODE_END, stopped_q)

endmodule

>>> sv/pge_coder.sv
// ----------------------------------------------------------------------------
// Prime gap coder
// Maps a prime and its predecessor to the prefix codeword for half the gap.
// ----------------------------------------------------------------------------
module pge_coder (
  input  logic [pge_pkg::DATA_W-1:0] value_i,
  input  logic [pge_pkg::DATA_W-1:0] prev_i,
  output pge_pkg::pge_code_t         code_o
);

  logic [pge_pkg::DATA_W-1:0] diff;
  logic [pge_pkg::DATA_W-2:0] half;
  logic [7:0]                 entry;
  logic                       small_gap;

  assign diff      = value_i - prev_i;
  assign half      = diff[pge_pkg::DATA_W-1:1];
  assign small_gap = (half[pge_pkg::DATA_W-2:4] == '0);
  assign entry     = small_gap ? pge_pkg::gap_entry(half[3:0]) : 8'h00;

  always_comb begin
    code_o = '0;
    unique case (entry[7:4])
      pge_pkg::TIER_1: begin
        code_o.code = pge_pkg::CODE_W'(entry[1:0]);
        code_o.len  = pge_pkg::LEN_W'(2);
      end
      pge_pkg::TIER_2: begin
        code_o.code = pge_pkg::CODE_W'(pge_pkg::TIER2_PREFIX | entry[3:0]);
        code_o.len  = pge_pkg::LEN_W'(4);
      end
      pge_pkg::TIER_3: begin
        code_o.code = pge_pkg::CODE_W'(pge_pkg::TIER3_PREFIX | {3'd0, entry[3:0]});
        code_o.len  = pge_pkg::LEN_W'(7);
      end
      default: begin
        if (half[pge_pkg::DATA_W-2:8] == '0) begin
          code_o.code = pge_pkg::CODE_W'({pge_pkg::SHORT_PREFIX, half[7:0]});
          code_o.len  = pge_pkg::LEN_W'(16);
        end else begin
          // long escape carries the prime itself
          code_o.code = (pge_pkg::CODE_W'(pge_pkg::ESC_PREFIX) << pge_pkg::VALUE_BITS)
                      | pge_pkg::CODE_W'(value_i & pge_pkg::VALUE_MASK);
          code_o.len  = pge_pkg::LEN_W'(8 + pge_pkg::VALUE_BITS);
        end
      end
    endcase
  end

endmodule

>>> tb/prime_gap_encoder_tb.sv
// ----------------------------------------------------------------------------
// Prime gap encoder testbench
// Drives one rising prime list through the encoder and checks every codeword,
// the end terminator with its CRC, and the error requests after the stop.
// Expected results come from a behavioral encoder kept in step with each
// accepted request. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module prime_gap_encoder_tb;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake on either side
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 110;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    pge_pkg::status_e           status;
    logic [pge_pkg::CODE_W-1:0] code;
    logic [pge_pkg::LEN_W-1:0]  len;
    logic [pge_pkg::CRC_W-1:0]  crc;
    logic                       mism;
  } codeword_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = pge_pkg::MODE_VALUE;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [79:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  // behavioral encoder state
  logic [31:0] last_prime = '0;
  logic [31:0] crc_acc = pge_pkg::CRC_INIT;
  logic        halted = 1'b0;
  codeword_t   codeword_q[$];

  logic [31:0] sent_prime = '0;
  int          sender_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  codeword_t   got, want;

  prime_gap_encoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // encoder model
  // ---------------------------------------------------------------------------
  // reflected CRC-32 fed one bit at a time, LSB first (same as bytes low first)
  function automatic logic [31:0] crc_after(input logic [31:0] c, input logic [31:0] v);
    logic [31:0] s;
    s = c;
    for (int i = 0; i < 32; i++) begin
      s = (s[0] ^ v[i]) ? ((s >> 1) ^ pge_pkg::CRC_POLY) : (s >> 1);
    end
    return s;
  endfunction

  task automatic predict_codeword(input pge_pkg::mode_e m, input logic [31:0] v);
    codeword_t   r;
    logic [31:0] half;
    r = '0;
    r.status = pge_pkg::STAT_ERR;
    if (halted) begin
      codeword_q.push_back(r);
    end else if (m == pge_pkg::MODE_END) begin
      halted = 1'b1;
      if (last_prime != 0) begin
        r.status = pge_pkg::STAT_END;
        r.code   = {pge_pkg::ESC_PREFIX, 32'h0};
        r.len    = 6'd40;
        r.crc    = ~crc_acc;
        r.mism   = (~crc_acc != v);
      end
      codeword_q.push_back(r);
    end else if ((v & ~pge_pkg::VALUE_MASK) != 0 ||
                 (last_prime == 0 ? (v != 2) : (v <= last_prime))) begin
      halted = 1'b1;
      codeword_q.push_back(r);
    end else begin
      crc_acc = crc_after(crc_acc, v);
      // 2 and 3 only seed the list
      if (v > 3) begin
        half = (v - last_prime) >> 1;
        r.status = pge_pkg::STAT_GAP;
        case (half)
          32'd3:   begin r.code = 40'b00;      r.len = 6'd2; end
          32'd6:   begin r.code = 40'b01;      r.len = 6'd2; end
          32'd5:   begin r.code = 40'b10;      r.len = 6'd2; end
          32'd1:   begin r.code = 40'b1100;    r.len = 6'd4; end
          32'd2:   begin r.code = 40'b1101;    r.len = 6'd4; end
          32'd9:   begin r.code = 40'b1110;    r.len = 6'd4; end
          32'd4:   begin r.code = 40'b1111000; r.len = 6'd7; end
          32'd7:   begin r.code = 40'b1111001; r.len = 6'd7; end
          32'd8:   begin r.code = 40'b1111010; r.len = 6'd7; end
          32'd10:  begin r.code = 40'b1111011; r.len = 6'd7; end
          32'd11:  begin r.code = 40'b1111100; r.len = 6'd7; end
          32'd12:  begin r.code = 40'b1111101; r.len = 6'd7; end
          32'd15:  begin r.code = 40'b1111110; r.len = 6'd7; end
          default: begin
            if (half <= 255) begin
              r.code = 40'({pge_pkg::SHORT_PREFIX, half[7:0]});
              r.len  = 6'd16;
            end else begin
              r.code = {pge_pkg::ESC_PREFIX, v};
              r.len  = 6'd40;
            end
          end
        endcase
        codeword_q.push_back(r);
      end
      last_prime = v;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stream drivers and result checker
  // ---------------------------------------------------------------------------
  task automatic send_item(input pge_pkg::mode_e m, input logic [31:0] v);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= m;
    s_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_codeword(m, v);
  endtask

  task automatic send_prime(input logic [31:0] v);
    sent_prime = v;
    send_item(pge_pkg::MODE_VALUE, v);
  endtask

  function automatic int tier_half_gap(input int idx);
    case (idx)
      0:  return 3;
      1:  return 6;
      2:  return 5;
      3:  return 1;
      4:  return 2;
      5:  return 9;
      6:  return 4;
      7:  return 7;
      8:  return 8;
      9:  return 10;
      10: return 11;
      11: return 12;
      default: return 15;
    endcase
  endfunction

  // mostly table gaps, some short escapes, a few long escapes; stays below the top
  function automatic logic [31:0] next_prime_after(input logic [31:0] prev);
    logic [63:0] gap;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 60)
      gap = 64'(2 * tier_half_gap($urandom_range(0, 12)) + $urandom_range(0, 1));
    else if (r < 65) gap = 64'd1;
    else if (r < 85) gap = 64'(2 * $urandom_range(13, 255) + $urandom_range(0, 1));
    else if (r < 96) gap = 64'($urandom_range(512, 1 << 20));
    else             gap = 64'($urandom_range(1 << 20, 1 << 26));
    if (64'(prev) + gap > 64'hFFFF_0000) gap = 64'd2;
    return prev + gap[31:0];
  endfunction

  always @(negedge clk_i) begin
    if (hold_left == 0 && hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got.status = pge_pkg::status_e'(m_axis_tuser_o);
      got.code   = m_axis_tdata_o[39:0];
      got.len    = m_axis_tdata_o[45:40];
      got.crc    = m_axis_tdata_o[77:46];
      got.mism   = m_axis_tdata_o[78];
      if (codeword_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: status=%0d code=%h len=%0d crc=%h mism=%b",
                   got.status, got.code, got.len, got.crc, got.mism);
      end else begin
        want = codeword_q.pop_front();
        if (got.status !== want.status || got.code !== want.code || got.len !== want.len ||
            got.crc !== want.crc || got.mism !== want.mism) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch exp: status=%0d code=%h len=%0d crc=%h mism=%b",
                     want.status, want.code, want.len, want.crc, want.mism);
            $display("         act: status=%0d code=%h len=%0d crc=%h mism=%b",
                     got.status, got.code, got.len, got.crc, got.mism);
          end
        end
      end
    end
  end

  // watchdog: ends the run when no request moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_list_start();
    send_prime(32'd2);
    send_prime(32'd3);
  endtask

  // every table entry, gap of one, short escape edges, long escape and a wide jump
  task automatic test_gap_tiers();
    for (int i = 0; i < 13; i++) send_prime(sent_prime + 2 * tier_half_gap(i));
    send_prime(sent_prime + 1);
    send_prime(sent_prime + 26);
    send_prime(sent_prime + 29);
    send_prime(sent_prime + 32);
    send_prime(sent_prime + 510);
    send_prime(sent_prime + 512);
    send_prime(sent_prime + 32'h8000_0000);
  endtask

  task automatic test_random_gaps(input int idle, input int stall, input int count);
    sender_idle_pct = idle;
    stall_pct       = stall;
    for (int i = 0; i < count; i++) send_prime(next_prime_after(sent_prime));
  endtask

  // receiver holds off while requests keep coming, so the input side stalls
  task automatic test_backpressure();
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_request    = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) send_prime(next_prime_after(sent_prime));
  endtask

  task automatic test_list_end();
    logic [31:0] control;
    sender_idle_pct = 10;
    stall_pct       = 10;
    send_prime(32'hFFFF_FFFF);
    control = ~crc_acc;
    if ($urandom_range(0, 1) == 1) control = control ^ (32'h1 << $urandom_range(0, 31));
    send_item(pge_pkg::MODE_END, control);
  endtask

  // block is stopped now: anything gives an error
  task automatic test_after_stop();
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(0, 3) == 0) send_item(pge_pkg::MODE_VALUE, sent_prime + 2);
      else send_item(pge_pkg::mode_e'($urandom_range(0, 1)), $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_list_start();
    test_gap_tiers();
    test_random_gaps(0, 0, PHASE_ITEMS);
    test_random_gaps(53, 0, PHASE_ITEMS);
    test_backpressure();
    test_random_gaps(0, 53, PHASE_ITEMS);
    test_random_gaps(10, 10, PHASE_ITEMS);
    test_list_end();
    test_after_stop();

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (codeword_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
